### rtl/tbp_pkg.sv
package tbp_pkg;

  typedef logic [1:0] ctr_t;

  localparam ctr_t CTR_MIN = 2'd0;
  localparam ctr_t CTR_MAX = 2'd3;
  localparam ctr_t DIR_RESET = 2'd3;
  localparam ctr_t CHOOSER_RESET = 2'd0;

  localparam int COUNT_W = 32;

  typedef enum logic [1:0] {
    ST_CLEAR = 2'b01,
    ST_RUN   = 2'b10
  } tbp_state_t;

  // Two-bit saturating counter step toward the given direction.
  function automatic ctr_t train2(input ctr_t c, input logic up);
    ctr_t r;
    if (up) begin
      r = (c == CTR_MAX) ? CTR_MAX : ctr_t'(c + 2'd1);
    end else begin
      r = (c == CTR_MIN) ? CTR_MIN : ctr_t'(c - 2'd1);
    end
    return r;
  endfunction

endpackage

### rtl/tbp_counter_bank.sv
module tbp_counter_bank import tbp_pkg::*; #(
  parameter int ENTRIES = 2048,
  parameter int IDX_W = 11
) (
  input  logic             clk,
  input  logic             rd_en,
  input  logic [IDX_W-1:0] rd_addr,
  output ctr_t             rd_data,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_addr,
  input  ctr_t             wr_data
);

  ctr_t mem [ENTRIES];

  // Read is old-data on a same-cycle write to the same entry; the caller forwards.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

endmodule

### rtl/tournament_branch_predictor_unit.sv
// Pipeline: an accepted request passes the table read and stage register, then the
// output register, which loads once the output is empty or taken. Throughput: one
// request per cycle while stage 1 is empty or advancing; each counter table has one
// read and one write port, is read at acceptance and written as the request leaves
// stage 1, with forwarding. Reset: history and correct count clear at once; then a
// clearing pass rewrites all TABLE_ENTRIES entries (2048 by default) of every table
// while in_ready stays low. TABLE_ENTRIES must be a power of two.
module tournament_branch_predictor_unit import tbp_pkg::*; #(
  parameter int TABLE_ENTRIES = 2048,
  parameter int HISTORY_BITS = 11
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [47:0]        branch_address,
  input  logic               taken,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               prediction,
  output logic               was_correct,
  output logic [COUNT_W-1:0] correct_count
);

  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam int WIDE_W = (IDX_W > HISTORY_BITS) ? IDX_W : HISTORY_BITS;

  tbp_state_t state;
  logic [IDX_W-1:0] clr_idx;

  logic [HISTORY_BITS-1:0] history;
  logic [WIDE_W-1:0] hist_wide;
  logic [COUNT_W-1:0] hit_total;
  logic [COUNT_W-1:0] hit_total_next;

  logic in_fire;
  logic s1_adv;
  logic [IDX_W-1:0] bi_in;
  logic [IDX_W-1:0] gi_in;

  // Stage 1 registers.
  logic s1_valid;
  logic [IDX_W-1:0] s1_bi;
  logic [IDX_W-1:0] s1_gi;
  logic s1_taken;
  logic s1_bim_fwd;
  logic s1_gsh_fwd;
  ctr_t s1_bim_fd;
  ctr_t s1_gsh_fd;
  ctr_t s1_cho_fd;

  ctr_t bim_rd, gsh_rd, cho_rd;
  ctr_t bim_c, gsh_c, cho_c;
  ctr_t bim_new, gsh_new, cho_new;
  logic bp, gp, pred, ok;

  logic wr_en;
  logic [IDX_W-1:0] bim_wa, gsh_wa;
  ctr_t bim_wd, gsh_wd, cho_wd;

  assign hist_wide = WIDE_W'(history);
  assign bi_in = branch_address[IDX_W-1:0];
  assign gi_in = branch_address[IDX_W-1:0] ^ hist_wide[IDX_W-1:0];

  assign s1_adv = s1_valid && (!out_valid || out_ready);
  assign in_ready = (state == ST_RUN) && (!s1_valid || s1_adv);
  assign in_fire = in_valid && in_ready;

  always_comb begin
    bim_c = s1_bim_fwd ? s1_bim_fd : bim_rd;
    gsh_c = s1_gsh_fwd ? s1_gsh_fd : gsh_rd;
    cho_c = s1_bim_fwd ? s1_cho_fd : cho_rd;
    bp = bim_c[1];
    gp = gsh_c[1];
    pred = cho_c[1] ? bp : gp;
    ok = (pred == s1_taken);
    bim_new = train2(bim_c, s1_taken);
    gsh_new = train2(gsh_c, s1_taken);
    cho_new = (bp != gp) ? train2(cho_c, bp == s1_taken) : cho_c;
    hit_total_next = hit_total;
    if (ok && (hit_total != {COUNT_W{1'b1}})) begin
      hit_total_next = hit_total + COUNT_W'(1);
    end
  end

  // The clearing pass and the update share each table's write port.
  always_comb begin
    if (state == ST_CLEAR) begin
      wr_en = 1'b1;
      bim_wa = clr_idx;
      gsh_wa = clr_idx;
      bim_wd = DIR_RESET;
      gsh_wd = DIR_RESET;
      cho_wd = CHOOSER_RESET;
    end else begin
      wr_en = s1_adv;
      bim_wa = s1_bi;
      gsh_wa = s1_gi;
      bim_wd = bim_new;
      gsh_wd = gsh_new;
      cho_wd = cho_new;
    end
  end

  tbp_counter_bank #(.ENTRIES(TABLE_ENTRIES), .IDX_W(IDX_W)) u_bimodal (
    .clk(clk), .rd_en(in_fire), .rd_addr(bi_in), .rd_data(bim_rd),
    .wr_en(wr_en), .wr_addr(bim_wa), .wr_data(bim_wd)
  );

  tbp_counter_bank #(.ENTRIES(TABLE_ENTRIES), .IDX_W(IDX_W)) u_gshare (
    .clk(clk), .rd_en(in_fire), .rd_addr(gi_in), .rd_data(gsh_rd),
    .wr_en(wr_en), .wr_addr(gsh_wa), .wr_data(gsh_wd)
  );

  tbp_counter_bank #(.ENTRIES(TABLE_ENTRIES), .IDX_W(IDX_W)) u_chooser (
    .clk(clk), .rd_en(in_fire), .rd_addr(bi_in), .rd_data(cho_rd),
    .wr_en(wr_en), .wr_addr(bim_wa), .wr_data(cho_wd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      clr_idx <= '0;
    end else begin
      case (state)
        ST_CLEAR: begin
          clr_idx <= clr_idx + IDX_W'(1);
          if (clr_idx == {IDX_W{1'b1}}) begin
            state <= ST_RUN;
          end
        end
        ST_RUN: begin
          state <= ST_RUN;
        end
        default: begin
          state <= ST_CLEAR;
          clr_idx <= '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      history <= '0;
      hit_total <= '0;
      s1_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_fire) begin
        history <= {history[HISTORY_BITS-2:0], taken};
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      if (s1_adv) begin
        hit_total <= hit_total_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // A request accepted while the one ahead writes back reads stale memory
  // data, so the fresh counter values are captured alongside it.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_bi <= bi_in;
      s1_gi <= gi_in;
      s1_taken <= taken;
      s1_bim_fwd <= s1_adv && (s1_bi == bi_in);
      s1_gsh_fwd <= s1_adv && (s1_gi == gi_in);
      s1_bim_fd <= bim_new;
      s1_gsh_fd <= gsh_new;
      s1_cho_fd <= cho_new;
    end
    if (s1_adv) begin
      prediction <= pred;
      was_correct <= ok;
      correct_count <= hit_total_next;
    end
  end

  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLEAR) |-> !in_ready)
    else $error("request accepted during the clearing pass");

  a_accept_moves_stage: assert property (@(posedge clk) disable iff (rst)
    (in_fire && s1_valid) |-> s1_adv)
    else $error("request accepted over a stalled stage");

  a_adv_loads_output: assert property (@(posedge clk) disable iff (rst)
    s1_adv |=> (out_valid && (correct_count == hit_total)))
    else $error("output register not loaded with the running count");

  a_count_monotonic: assert property (@(posedge clk) disable iff (rst)
    s1_valid |=> (hit_total >= $past(hit_total)))
    else $error("correct count decreased");

endmodule

### dv/tournament_branch_predictor_unit_tb.sv
`timescale 1ns / 1ps

module tournament_branch_predictor_unit_tb;
  import tbp_pkg::*;

  localparam int TABLE_ENTRIES = 2048;
  localparam int HISTORY_BITS = 11;
  localparam int IDX_W = 11;
  localparam int RANDOM_ITEMS = 1380;
  localparam int CALM_ITEMS = 200;
  localparam int CYCLE_LIMIT = 300000;

  typedef struct {
    logic              pred;
    logic              hit;
    logic [COUNT_W-1:0] hits;
  } verdict_t;

  // Tracks the predictor tables and keeps the verdicts still owed by the block.
  class branch_scoreboard;
    ctr_t               bimodal_ctr [TABLE_ENTRIES];
    ctr_t               gshare_ctr [TABLE_ENTRIES];
    ctr_t               chooser_ctr [TABLE_ENTRIES];
    logic [HISTORY_BITS-1:0] history;
    logic [COUNT_W-1:0] hit_count;
    verdict_t           owed [$];
    int                 errors;

    function new();
      foreach (bimodal_ctr[i]) begin
        bimodal_ctr[i] = DIR_RESET;
        gshare_ctr[i] = DIR_RESET;
        chooser_ctr[i] = CHOOSER_RESET;
      end
      history = '0;
      hit_count = '0;
      errors = 0;
    endfunction

    function ctr_t bump(ctr_t c, logic up);
      if (up) begin
        return (c == CTR_MAX) ? c : ctr_t'(c + 1);
      end
      return (c == CTR_MIN) ? c : ctr_t'(c - 1);
    endfunction

    function void note_branch(logic [47:0] addr, logic t);
      logic [IDX_W-1:0] bi;
      logic [IDX_W-1:0] gi;
      logic             bp;
      logic             gp;
      ctr_t             ch;
      verdict_t         v;
      bi = addr[IDX_W-1:0];
      gi = addr[IDX_W-1:0] ^ IDX_W'(history);
      bp = bimodal_ctr[bi][1];
      gp = gshare_ctr[gi][1];
      ch = chooser_ctr[bi];
      v.pred = ch[1] ? bp : gp;
      v.hit = (v.pred == t);
      bimodal_ctr[bi] = bump(bimodal_ctr[bi], t);
      gshare_ctr[gi] = bump(gshare_ctr[gi], t);
      history = {history[HISTORY_BITS-2:0], t};
      // Only a disagreement between the two components moves the chooser.
      if (bp != gp) begin
        chooser_ctr[bi] = bump(ch, bp == t);
      end
      if (v.hit && hit_count != '1) begin
        hit_count = hit_count + 1;
      end
      v.hits = hit_count;
      owed.insert(owed.size(), v);
    endfunction

    task report_mismatch(string what, logic [COUNT_W-1:0] got, logic [COUNT_W-1:0] want);
      $display("%0t: mismatch in %s: got %0d, expected %0d", $time, what, got, want);
      errors++;
    endtask

    task check_result(logic pred, logic hit, logic [COUNT_W-1:0] hits);
      verdict_t v;
      if (owed.size() == 0) begin
        report_mismatch("unexpected result", 0, 0);
      end else begin
        v = owed.pop_front();
        if (pred !== v.pred) report_mismatch("prediction", pred, v.pred);
        if (hit !== v.hit) report_mismatch("was_correct", hit, v.hit);
        if (hits !== v.hits) report_mismatch("correct_count", hits, v.hits);
      end
    endtask
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [47:0]        branch_address = '0;
  logic               taken = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic               prediction;
  logic               was_correct;
  logic [COUNT_W-1:0] correct_count;

  branch_scoreboard sb = new();
  logic [IDX_W-1:0] hot_index [16];
  bit               calm = 1'b0;
  int               sent = 0;
  int               cycles = 0;

  tournament_branch_predictor_unit uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .branch_address(branch_address),
    .taken(taken),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .prediction(prediction),
    .was_correct(was_correct),
    .correct_count(correct_count)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tournament_branch_predictor_unit_tb failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      sb.check_result(prediction, was_correct, correct_count);
    end
  end

  // Result side: ready drops in random bursts until the quiet tail of the run.
  initial begin
    int n;
    @(posedge clk);
    forever begin
      if (calm) begin
        out_ready <= 1'b1;
        @(posedge clk);
      end else if ($urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        n = $urandom_range(1, 9);
        repeat (n) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        n = $urandom_range(1, 12);
        repeat (n) @(posedge clk);
      end
    end
  end

  function automatic logic [47:0] any_address();
    logic [47:0] a;
    a[47:32] = 16'($urandom);
    a[31:0] = $urandom;
    return a;
  endfunction

  // Random upper bits over one of a few hot table indexes, so entries get trained.
  function automatic logic [47:0] hot_address();
    logic [47:0] a;
    a = any_address();
    a[IDX_W-1:0] = hot_index[$urandom_range(0, 15)];
    return a;
  endfunction

  task automatic send_branch(input logic [47:0] addr, input logic t);
    int gap;
    gap = (!calm && $urandom_range(0, 3) == 0) ? $urandom_range(1, 9) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    branch_address <= addr;
    taken <= t;
    do @(posedge clk); while (!in_ready);
    sb.note_branch(addr, t);
    sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.owed.size() != 0) @(posedge clk);
  endtask

  task automatic run_loop_branch();
    logic [47:0] a;
    int          period;
    int          reps;
    a = hot_address();
    period = $urandom_range(2, 6);
    reps = $urandom_range(2, 4);
    for (int i = 0; i < period * reps; i++) begin
      send_branch(a, (i % period) != period - 1);
    end
  endtask

  // The second branch repeats the outcome of the first, which only gshare can learn.
  task automatic run_correlated_pair();
    logic [47:0] a;
    logic [47:0] b;
    logic        t;
    int          n;
    a = hot_address();
    b = hot_address();
    n = $urandom_range(3, 8);
    repeat (n) begin
      t = 1'($urandom);
      send_branch(a, t);
      send_branch(b, t);
    end
  endtask

  task automatic run_biased_branch();
    logic [47:0] a;
    logic        flip;
    int          n;
    a = hot_address();
    flip = 1'($urandom);
    n = $urandom_range(4, 16);
    repeat (n) send_branch(a, ($urandom_range(0, 7) != 0) ^ flip);
  endtask

  task automatic run_noise();
    int n;
    n = $urandom_range(1, 4);
    repeat (n) send_branch(any_address(), 1'($urandom));
  endtask

  initial begin
    int kind;
    bit drained_mid;
    hot_index[0] = '0;
    hot_index[1] = '1;
    for (int i = 2; i < 16; i++) hot_index[i] = IDX_W'($urandom);
    drained_mid = 1'b0;

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Address extremes and both outcomes.
    send_branch(48'h0, 1'b1);
    send_branch(48'hFFFF_FFFF_FFFF, 1'b0);
    send_branch(48'hAAAA_AAAA_AAAA, 1'b1);
    send_branch(48'h5555_5555_5555, 1'b0);
    send_branch(48'h0000_0000_07FF, 1'b1);
    send_branch(48'hFFFF_FFFF_F800, 1'b0);
    // One address driven down to the floor and back up: counters saturate at
    // both ends, and the shifting history makes the two components disagree,
    // which trains the chooser in both directions.
    repeat (5) send_branch(48'h0000_0000_0123, 1'b0);
    repeat (5) send_branch(48'h0000_0000_0123, 1'b1);
    repeat (4) send_branch(48'h0000_0000_0123, 1'b0);
    send_branch(48'h0000_0000_0123, 1'b1);
    send_branch(48'h8000_0000_0123, 1'b0);
    drain();

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      if (sent >= RANDOM_ITEMS - CALM_ITEMS) calm = 1'b1;
      if (!drained_mid && sent >= RANDOM_ITEMS / 2) begin
        drained_mid = 1'b1;
        drain();
      end
      kind = $urandom_range(0, 9);
      if (kind < 4) run_loop_branch();
      else if (kind < 7) run_correlated_pair();
      else if (kind < 9) run_biased_branch();
      else run_noise();
    end
    in_valid <= 1'b0;

    while (sb.owed.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.owed.size() == 0) begin
      $display("tournament_branch_predictor_unit_tb passed");
    end else begin
      $display("tournament_branch_predictor_unit_tb failed");
    end
    $finish;
  end

endmodule
